/* rtl/lsra_pkg.sv */
`timescale 1ns / 1ps
package lsra_pkg;
  localparam int unsigned MaxRegisters = 16;
  localparam int unsigned IdW = 16;
  localparam int unsigned PosW = 16;
  localparam int unsigned RegW = 5;
  localparam int unsigned SlotW = 16;
  localparam int unsigned CfgW = 5;
  localparam logic [CfgW-1:0] ResetRegs = 5'd2;
  localparam logic [SlotW-1:0] SlotMax = 16'hFFFF;
endpackage

/* rtl/linear_scan_register_allocator_unit.sv */
`timescale 1ns / 1ps
// Linear scan register allocator.
// Input channel: interval_id/start/end, taken when start is high and busy
// low. Intervals must arrive in non-decreasing start order; the block does not check it.
// Output: one or two result items per input item, each shown for one cycle
// with result_valid_o; last_result_o marks the final one. On an eviction the
// evicted interval (to a stack slot) comes first, then the new interval.
// The receiver cannot stall; results are never held.
// Configuration: cfg_valid_i/cfg_ready_o/cfg_data_i write num_registers and
// restart the allocator. Write only while idle.
// Scans: the active table sits in a one-port-read memory scanned one entry per
// cycle, entries 0 to MAX_REGISTERS-1 each scan. Expiry takes one scan per expiring
// interval plus a final scan; state SAlloc then allocates. With the pool empty a
// candidate scan follows, and an eviction adds state SOut2 for its second result.
// Busy stays high until the last result of an item, so a new item is taken only
// after the previous one is done.
// Reset: active set empty, pool holds registers 1 and 2, slot counter zero.
module linear_scan_register_allocator_unit #(
  parameter int unsigned MAX_REGISTERS = lsra_pkg::MaxRegisters
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic [lsra_pkg::IdW-1:0] interval_id_i,
  input  logic [lsra_pkg::PosW-1:0] interval_start_i,
  input  logic [lsra_pkg::PosW-1:0] interval_end_i,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [lsra_pkg::CfgW-1:0] cfg_data_i,
  output logic result_valid_o,
  output logic [lsra_pkg::IdW-1:0] target_id_o,
  output logic placed_on_stack_o,
  output logic [lsra_pkg::RegW-1:0] register_number_o,
  output logic [lsra_pkg::SlotW-1:0] stack_slot_o,
  output logic last_result_o
);
  import lsra_pkg::*;
  localparam int unsigned AW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGISTERS + 1);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SExp = 3'd1;
  localparam logic [2:0] SAlloc = 3'd2;
  localparam logic [2:0] SCand = 3'd3;
  localparam logic [2:0] SOut2 = 3'd4;

  typedef struct packed {
    logic [IdW-1:0] tag;
    logic [PosW-1:0] fin;
    logic [RegW-1:0] rnum;
  } entry_t;

  entry_t mem [MAX_REGISTERS];
  entry_t rd_q;
  logic [AW-1:0] rd_addr;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;

  logic [MAX_REGISTERS-1:0] valid_q, valid_d;
  logic [RegW-1:0] pool_q [MAX_REGISTERS];
  logic [CW-1:0] count_q, count_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [2:0] state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;      // scan counter; its entry arrives in rd_q in the cycle after
  logic rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic best_f_q, best_f_d;
  logic [AW-1:0] best_q, best_d;
  entry_t best_e_q, best_e_d;
  logic [IdW-1:0] id_q;
  logic [PosW-1:0] st_q, en_q;
  logic pop, push;
  logic [RegW-1:0] push_val;

  logic [CW-1:0] cfg_n;
  always_comb begin
    logic [CfgW-1:0] v;
    v = cfg_data_i;
    if (v == '0) v = CfgW'(1);
    if (32'(v) > MAX_REGISTERS) v = CfgW'(MAX_REGISTERS > 31 ? 31 : MAX_REGISTERS);
    cfg_n = CW'(v);
  end

  assign busy = (state_q != SIdle);
  assign cfg_ready_o = (state_q == SIdle);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  assign rd_addr = idx_q[AW-1:0];
  logic scan_end;
  assign scan_end = (idx_q == CW'(MAX_REGISTERS));

  // current scanned entry
  logic cur_v;
  assign cur_v = rd_vld_q && valid_q[rd_idx_q];

  logic [AW-1:0] free_idx;
  logic free_f;
  always_comb begin
    free_idx = '0;
    free_f = 1'b0;
    for (int i = MAX_REGISTERS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = AW'(i);
        free_f = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    best_f_d = best_f_q;
    best_d = best_q;
    best_e_d = best_e_q;
    valid_d = valid_q;
    count_d = count_q;
    slot_d = slot_q;
    pop = 1'b0;
    push = 1'b0;
    push_val = best_e_q.rnum;
    wr_en = 1'b0;
    wr_addr = free_idx;
    wr_data = '{tag: id_q, fin: en_q, rnum: pool_q[0]};
    result_valid_o = 1'b0;
    target_id_o = id_q;
    placed_on_stack_o = 1'b0;
    register_number_o = '0;
    stack_slot_o = '0;
    last_result_o = 1'b1;
    case (state_q)
      SIdle: begin
        if (start) begin
          state_d = SExp;
          idx_d = '0;
          best_f_d = 1'b0;
        end
      end
      SExp: begin
        if (cur_v && rd_q.fin < st_q &&
            (!best_f_q || rd_q.fin < best_e_q.fin ||
             (rd_q.fin == best_e_q.fin && rd_q.rnum < best_e_q.rnum))) begin
          best_f_d = 1'b1;
          best_d = rd_idx_q;
          best_e_d = rd_q;
        end
        if (!scan_end) begin
          idx_d = idx_q + 1'b1;
        end else if (best_f_d) begin
          // retire smallest expired end and rescan
          valid_d[best_d] = 1'b0;
          push_val = best_e_d.rnum;
          if (count_q < CW'(MAX_REGISTERS)) push = 1'b1;
          if (count_q < CW'(MAX_REGISTERS)) count_d = count_q + 1'b1;
          idx_d = '0;
          best_f_d = 1'b0;
        end else begin
          state_d = SAlloc;
        end
      end
      SAlloc: begin
        if (count_q != '0) begin
          pop = 1'b1;
          count_d = count_q - 1'b1;
          if (free_f) begin
            wr_en = 1'b1;
            valid_d[free_idx] = 1'b1;
          end
          result_valid_o = 1'b1;
          register_number_o = pool_q[0];
          state_d = SIdle;
        end else begin
          state_d = SCand;
          idx_d = '0;
          best_f_d = 1'b0;
        end
      end
      SCand: begin
        if (cur_v && (!best_f_q || rd_q.fin > best_e_q.fin ||
            (rd_q.fin == best_e_q.fin && rd_q.rnum > best_e_q.rnum))) begin
          best_f_d = 1'b1;
          best_d = rd_idx_q;
          best_e_d = rd_q;
        end
        if (!scan_end) begin
          idx_d = idx_q + 1'b1;
        end else begin
          result_valid_o = 1'b1;
          placed_on_stack_o = 1'b1;
          stack_slot_o = slot_q;
          if (slot_q != SlotMax) slot_d = slot_q + 1'b1;
          if (best_f_d && best_e_d.fin > en_q) begin
            target_id_o = best_e_d.tag;
            last_result_o = 1'b0;
            wr_en = 1'b1;
            wr_addr = best_d;
            wr_data = '{tag: id_q, fin: en_q, rnum: best_e_d.rnum};
            state_d = SOut2;
          end else begin
            state_d = SIdle;
          end
        end
      end
      SOut2: begin
        result_valid_o = 1'b1;
        register_number_o = best_e_q.rnum;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      best_f_q <= 1'b0;
      valid_q <= '0;
      count_q <= CW'(ResetRegs);
      slot_q <= '0;
      for (int i = 0; i < MAX_REGISTERS; i++) pool_q[i] <= RegW'(i + 1);
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      rd_vld_q <= !scan_end && (state_q == SExp || state_q == SCand) && idx_d != '0;
      rd_idx_q <= idx_q[AW-1:0];
      best_f_q <= best_f_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_n;
        valid_q <= '0;
        slot_q <= '0;
        for (int i = 0; i < MAX_REGISTERS; i++) pool_q[i] <= RegW'(i + 1);
      end else begin
        valid_q <= valid_d;
        count_q <= count_d;
        slot_q <= slot_d;
        if (pop) begin
          for (int i = 0; i < MAX_REGISTERS - 1; i++) pool_q[i] <= pool_q[i + 1];
        end else if (push) begin
          pool_q[count_q[AW-1:0]] <= push_val;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    best_e_q <= best_e_d;
    if (start && !busy) begin
      id_q <= interval_id_i;
      st_q <= interval_start_i;
      en_q <= interval_end_i;
    end
  end

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside item");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_REGISTERS)) else $error("pool overflow");
  a_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_result_o) |=> (result_valid_o && last_result_o))
    else $error("second result missing");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (valid_q == '0)) else $error("restart failed");
endmodule

/* tb/lsra_checker.sv */
`timescale 1ns / 1ps
module lsra_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic [lsra_pkg::IdW-1:0]     interval_id_i,
  input  logic [lsra_pkg::PosW-1:0]    interval_start_i,
  input  logic [lsra_pkg::PosW-1:0]    interval_end_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [lsra_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         result_valid_o,
  input  logic [lsra_pkg::IdW-1:0]     target_id_o,
  input  logic                         placed_on_stack_o,
  input  logic [lsra_pkg::RegW-1:0]    register_number_o,
  input  logic [lsra_pkg::SlotW-1:0]   stack_slot_o,
  input  logic                         last_result_o,
  output int                           pending_o,
  output int                           errors_o
);
  import lsra_pkg::*;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic             on_stack;
    logic [RegW-1:0]  reg_num;
    logic [SlotW-1:0] slot;
    logic             last;
  } placement_t;

  placement_t placements_q[$];

  logic             live_valid [MaxRegisters];
  logic [IdW-1:0]   live_tag   [MaxRegisters];
  logic [PosW-1:0]  live_end   [MaxRegisters];
  logic [RegW-1:0]  live_reg   [MaxRegisters];
  logic [RegW-1:0]  pool       [MaxRegisters];
  int               pool_count;
  logic [SlotW-1:0] slot_next;
  int               reg_total;
  int               err_count = 0;
  int               pend = 0;

  assign errors_o = err_count;
  assign pending_o = pend;

  function automatic int clamp_regs(logic [CfgW-1:0] v);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > MaxRegisters) n = MaxRegisters;
    return n;
  endfunction

  task automatic restart_alloc(int n);
    reg_total = n;
    for (int i = 0; i < MaxRegisters; i++) begin
      live_valid[i] = 1'b0;
      live_tag[i] = '0;
      live_end[i] = '0;
      live_reg[i] = '0;
      pool[i] = (i < n) ? RegW'(i + 1) : '0;
    end
    pool_count = n;
    slot_next = '0;
  endtask

  function automatic logic [SlotW-1:0] grab_slot();
    logic [SlotW-1:0] s;
    s = slot_next;
    if (slot_next != SlotMax) slot_next = slot_next + 1'b1;
    return s;
  endfunction

  task automatic add_placement(placement_t p);
    placements_q = {placements_q, p};
  endtask

  task automatic place_interval(logic [IdW-1:0] id, logic [PosW-1:0] s,
                                logic [PosW-1:0] e);
    int best;
    int cand;
    logic [RegW-1:0] r;
    placement_t p;
    // retire expired intervals, earliest end first
    forever begin
      best = -1;
      for (int i = 0; i < MaxRegisters; i++) begin
        if (live_valid[i] && live_end[i] < s) begin
          if (best < 0 || live_end[i] < live_end[best] ||
              (live_end[i] == live_end[best] && live_reg[i] < live_reg[best]))
            best = i;
        end
      end
      if (best < 0) break;
      live_valid[best] = 1'b0;
      if (pool_count < MaxRegisters) begin
        pool[pool_count] = live_reg[best];
        pool_count++;
      end
    end
    if (pool_count > 0) begin
      r = pool[0];
      for (int j = 1; j < pool_count; j++) pool[j-1] = pool[j];
      pool_count--;
      pool[pool_count] = '0;
      for (int i = 0; i < MaxRegisters; i++) begin
        if (!live_valid[i]) begin
          live_valid[i] = 1'b1;
          live_tag[i] = id;
          live_end[i] = e;
          live_reg[i] = r;
          break;
        end
      end
      p = '{id: id, on_stack: 1'b0, reg_num: r, slot: '0, last: 1'b1};
      add_placement(p);
    end else begin
      cand = -1;
      for (int i = 0; i < MaxRegisters; i++) begin
        if (live_valid[i]) begin
          if (cand < 0 || live_end[i] > live_end[cand] ||
              (live_end[i] == live_end[cand] && live_reg[i] > live_reg[cand]))
            cand = i;
        end
      end
      if (cand >= 0 && live_end[cand] > e) begin
        // evict the candidate to the stack, hand its register over
        p = '{id: live_tag[cand], on_stack: 1'b1, reg_num: '0,
              slot: grab_slot(), last: 1'b0};
        add_placement(p);
        live_tag[cand] = id;
        live_end[cand] = e;
        p = '{id: id, on_stack: 1'b0, reg_num: live_reg[cand], slot: '0, last: 1'b1};
        add_placement(p);
      end else begin
        p = '{id: id, on_stack: 1'b1, reg_num: '0, slot: grab_slot(), last: 1'b1};
        add_placement(p);
      end
    end
  endtask

  always @(posedge clk_i) begin
    placement_t want;
    placement_t got;
    if (!rst_ni) begin
      placements_q.delete();
      restart_alloc(clamp_regs(ResetRegs));
    end else begin
      if (result_valid_o) begin
        got = '{id: target_id_o, on_stack: placed_on_stack_o,
                reg_num: register_number_o, slot: stack_slot_o, last: last_result_o};
        if (placements_q.size() == 0) begin
          $display("%0t: unexpected result id=%h stack=%b reg=%0d slot=%0d last=%b",
                   $time, got.id, got.on_stack, got.reg_num, got.slot, got.last);
          err_count = err_count + 1;
        end else begin
          want = placements_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected id=%h stack=%b reg=%0d slot=%0d last=%b",
                     $time, want.id, want.on_stack, want.reg_num, want.slot, want.last);
            $display("%0t:          actual   id=%h stack=%b reg=%0d slot=%0d last=%b",
                     $time, got.id, got.on_stack, got.reg_num, got.slot, got.last);
            err_count = err_count + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) restart_alloc(clamp_regs(cfg_data_i));
      if (start && !busy) place_interval(interval_id_i, interval_start_i, interval_end_i);
    end
    pend = placements_q.size();
  end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import lsra_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [IdW-1:0]   interval_id_i;
  logic [PosW-1:0]  interval_start_i;
  logic [PosW-1:0]  interval_end_i;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CfgW-1:0]  cfg_data_i;
  logic             result_valid_o;
  logic [IdW-1:0]   target_id_o;
  logic             placed_on_stack_o;
  logic [RegW-1:0]  register_number_o;
  logic [SlotW-1:0] stack_slot_o;
  logic             last_result_o;
  int               pending;
  int               errors;

  int               cur_start;
  int               sent;

  linear_scan_register_allocator_unit dut (.*);
  lsra_checker u_checker (.*, .pending_o(pending), .errors_o(errors));

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Hold the item until the block takes it.
  task automatic send_interval(logic [IdW-1:0] id, logic [PosW-1:0] s,
                               logic [PosW-1:0] e);
    start <= 1'b1;
    interval_id_i <= id;
    interval_start_i <= s;
    interval_end_i <= e;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [CfgW-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_start = 0;
  endtask

  task automatic random_interval(bit tail);
    int s;
    int e;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      s = $urandom_range(0, 65535);
    end else begin
      if (pick < 8) cur_start = $urandom_range(0, 65535);
      else cur_start = cur_start + $urandom_range(0, 6);
      if (cur_start > 65535) cur_start = 65535;
      s = cur_start;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) e = 65535;
    else if (pick < 10) e = $urandom_range(0, 65535);
    else e = s + $urandom_range(0, 40);
    if (e > 65535) e = 65535;
    send_interval(IdW'($urandom), PosW'(s), PosW'(e));
    if (!tail && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 18));
  endtask

  initial begin
    logic [CfgW-1:0] settings [10];
    settings = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'd2, 5'd8, 5'd4, 5'd16};
    sent = 0;
    cur_start = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    interval_id_i = '0;
    interval_start_i = '0;
    interval_end_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: two registers after reset.
    send_interval(16'h0001, 16'd0, 16'd10);
    send_interval(16'h0002, 16'd0, 16'd20);
    send_interval(16'h0003, 16'd1, 16'd15);  // evict the later end
    send_interval(16'h0004, 16'd2, 16'd20);  // candidate ends earlier: new one spills
    send_interval(16'hFFFF, 16'd3, 16'd0);
    send_interval(16'h0005, 16'd30, 16'd50); // two expire together
    send_interval(16'h0006, 16'd30, 16'd50);
    send_interval(16'h0007, 16'd31, 16'd50); // candidate tie on end
    send_interval(16'h0008, 16'd60, 16'd70); // tied ends expire together
    send_interval(16'h0000, 16'd5, 16'd6);   // start order broken
    send_interval(16'h0009, 16'hFFFF, 16'hFFFF);
    send_interval(16'h000A, 16'hFFFF, 16'hFFFF);
    send_interval(16'h000B, 16'hFFFF, 16'h0000);
    idle_cycles(3);
    write_regs(5'd1);
    send_interval(16'h0101, 16'd0, 16'd100);
    send_interval(16'h0102, 16'd1, 16'd50);
    send_interval(16'h0103, 16'd2, 16'd200);
    send_interval(16'h0104, 16'd101, 16'd101);

    for (int ph = 0; ph < 10; ph++) begin
      write_regs(settings[ph]);
      if (ph == 3) cur_start = $urandom_range(60000, 65000);
      for (int k = 0; k < 95; k++) begin
        if (ph == 4 && k == 40) begin
          // hold off until the block has nothing left outstanding
          start <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        random_interval(ph >= 8);
      end
    end
    write_regs(5'($urandom_range(0, 31)));
    for (int k = 0; k < 30; k++) random_interval(1'b1);

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
